### hdl/step_pulse_generator_macros.svh
// Assertion macros used by the step pulse generator engine.
`ifndef STEP_PULSE_GENERATOR_MACROS_SVH
`define STEP_PULSE_GENERATOR_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is held.
`define SPG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, with an implication built from the antecedent and consequent the caller gives.
`define SPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`SPG_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

### hdl/spg_pkg.sv
// Types and constants of the step pulse generator.
package spg_pkg;

	localparam int unsigned CountWidth  = 16;
	localparam int unsigned HalfWidth   = 31;
	localparam int unsigned ElapsWidth  = 32;
	localparam int unsigned DataInWidth = 16;
	localparam int unsigned DataOutWidth = 24;

	typedef enum logic [2:0] {
		ACT_TICK       = 3'd0,
		ACT_LOAD       = 3'd1,
		ACT_START      = 3'd2,
		ACT_LOAD_START = 3'd3,
		ACT_STOP       = 3'd4,
		ACT_RESET      = 3'd5
	} spg_action_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} spg_phase_t;

	typedef struct packed {
		logic                  step_out;
		logic                  dir_out;
		logic                  finished;
		spg_phase_t            phase_code;
		logic [CountWidth-1:0] steps_left;
	} spg_result_t;

endpackage

### hdl/spg_engine.sv
// Motion state of the step pulse generator and its per-item update.
`include "step_pulse_generator_macros.svh"

module spg_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic [spg_pkg::HalfWidth-1:0]       half_period,
	input  logic [2:0]                          action,
	input  logic [spg_pkg::CountWidth-1:0]      step_count,
	output spg_pkg::spg_result_t                result
);
	import spg_pkg::*;

	spg_phase_t              phase_q, phase_d;
	logic [ElapsWidth-1:0]   elapsed_q, elapsed_d;
	logic [CountWidth-1:0]   remaining_q, remaining_d;
	logic [CountWidth-1:0]   stored_q, stored_d;
	logic                    dir_q, dir_d;
	logic                    fin;

	logic [CountWidth-1:0]   run_count;
	logic [CountWidth-1:0]   mag;
	logic [CountWidth:0]     sum;
	logic [CountWidth-1:0]   sum_sat;
	logic [ElapsWidth-1:0]   elapsed_inc;
	logic                    phase_done;

	// Magnitude of a two's complement count; the most negative value maps to 2^15.
	assign run_count = (spg_action_t'(action) == ACT_LOAD_START) ? step_count : stored_q;
	assign mag       = run_count[CountWidth-1] ? (~run_count + 1'b1) : run_count;
	assign sum       = {1'b0, remaining_q} + {1'b0, mag};
	assign sum_sat   = sum[CountWidth] ? {CountWidth{1'b1}} : sum[CountWidth-1:0];

	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
	assign phase_done  = elapsed_inc >= {1'b0, half_period};

	always_comb begin
		phase_d     = phase_q;
		elapsed_d   = elapsed_q;
		remaining_d = remaining_q;
		stored_d    = stored_q;
		dir_d       = dir_q;
		fin         = 1'b0;
		unique case (spg_action_t'(action))
			ACT_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (!phase_done) begin
						elapsed_d = elapsed_inc;
					end else begin
						elapsed_d = '0;
						if (phase_q == PH_HIGH) begin
							phase_d = PH_LOW;
							if (remaining_q != '0) begin
								remaining_d = remaining_q - 1'b1;
							end
						end else if (remaining_q == '0) begin
							fin     = 1'b1;
							phase_d = PH_IDLE;
							dir_d   = 1'b0;
						end else begin
							phase_d = PH_HIGH;
						end
					end
				end
			end
			ACT_LOAD: begin
				stored_d = step_count;
			end
			ACT_START, ACT_LOAD_START: begin
				stored_d    = run_count;
				remaining_d = sum_sat;
				elapsed_d   = '0;
				if (sum_sat == '0) begin
					fin     = 1'b1;
					phase_d = PH_IDLE;
					dir_d   = 1'b0;
				end else begin
					phase_d = PH_HIGH;
					dir_d   = ~run_count[CountWidth-1];
				end
			end
			ACT_STOP: begin
				phase_d   = PH_IDLE;
				dir_d     = 1'b0;
				elapsed_d = '0;
			end
			ACT_RESET: begin
				remaining_d = '0;
				phase_d     = PH_IDLE;
				dir_d       = 1'b0;
				elapsed_d   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			elapsed_q   <= '0;
			remaining_q <= '0;
			stored_q    <= '0;
			dir_q       <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			elapsed_q   <= elapsed_d;
			remaining_q <= remaining_d;
			stored_q    <= stored_d;
			dir_q       <= dir_d;
		end
	end

	assign result.step_out   = (phase_d == PH_HIGH);
	assign result.dir_out    = (phase_d != PH_IDLE) && dir_d;
	assign result.finished   = fin;
	assign result.phase_code = phase_d;
	assign result.steps_left = remaining_d;

	// A high phase always has at least the current step still counted.
	`SPG_ASSERT_IMP(a_high_has_steps, clk, arst_n, phase_q == PH_HIGH, remaining_q != '0, "high phase with no steps left")
	`SPG_ASSERT_IMP(a_idle_no_dir, clk, arst_n, phase_q == PH_IDLE, !dir_q && elapsed_q == '0, "idle with direction or tick count set")
	`SPG_ASSERT_IMP(a_fin_goes_idle, clk, arst_n, advance && fin, ##1 phase_q == PH_IDLE, "run finished but not idle")

endmodule

### hdl/step_pulse_generator.sv
// Top level of the step pulse generator: item registers and configuration.
//
// Stepper step/direction generator driven by a stream of items, each either one
// tick of the time base or a command (load count, start, load and start, stop,
// reset). It accepts one item every clock cycle unless stalled and returns
// exactly one result item per input item, via the input register, where the
// motion state is updated, then the result register. The output register lets
// a new item enter while a result waits; the input stalls only when both
// registers are full. The user writes half_period over the cfg port only while
// no item is in flight, unchecked by the block; it takes effect on the next tick.

module step_pulse_generator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [spg_pkg::HalfWidth-1:0]           cfg_data,      // half_period
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [spg_pkg::DataInWidth-1:0]         s_tdata,       // step_count
	input  logic [2:0]                              s_tuser,       // action
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// step_out, dir_out, phase_code[1:0], steps_left[15:0], zero pad
	output logic [spg_pkg::DataOutWidth-1:0]        m_tdata,
	output logic                                    m_tlast        // finished
);
	import spg_pkg::*;

	logic [HalfWidth-1:0]  half_period_q;
	logic                  valid_s1;
	logic [2:0]            action_s1;
	logic [CountWidth-1:0] count_s1;
	logic                  valid_s2;
	spg_result_t           result_s2;
	spg_result_t           result;
	logic                  advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= '0;
		end else if (cfg_valid) begin
			half_period_q <= cfg_data;
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			count_s1  <= s_tdata;
		end
	end

	spg_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.half_period (half_period_q),
		.action      (action_s1),
		.step_count  (count_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = result_s2.finished;
	assign m_tdata  = {4'd0, result_s2.steps_left, result_s2.phase_code,
		result_s2.dir_out, result_s2.step_out};

endmodule
